[hdl/attribute_row_bit_packer_macros.svh]
// assertion macros for the attribute row bit packer
`ifndef ATTRIBUTE_ROW_BIT_PACKER_MACROS_SVH
`define ATTRIBUTE_ROW_BIT_PACKER_MACROS_SVH

// property must hold at every clock edge outside reset
`define ABP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ABP_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hdl/abp_pkg.sv]
// shared types, constants and codes for the attribute row bit packer
package abp_pkg;

    localparam int WORD_BITS_DEF    = 32;
    localparam int POINTER_BITS_DEF = 64;
    localparam int MAX_WORDS_DEF    = 64;

    localparam int KIND_W     = 3;
    localparam int BITS_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int OFF_OUT_W  = 11;
    localparam int CNT_OUT_W  = 7;
    localparam int PTR_CNT_W  = 7;

    localparam int MAX_FIELD_BITS = 64;

    localparam logic [BITS_W-1:0]    WIDE_BITS   = 7'd64;
    localparam logic [PTR_CNT_W-1:0] PTR_CNT_MAX = 7'd127;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PLAIN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BOOL    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WIDE64  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STR_PTR = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FAC_PTR = 3'd5;

    localparam logic [STATUS_W-1:0] ST_PLACED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic              command;
        logic [KIND_W-1:0] attr_kind;
        logic [BITS_W-1:0] requested_bits;
        logic              map_select;
    } abp_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OFF_OUT_W-1:0] bit_offset;
        logic [BITS_W-1:0]    bit_count;
        logic [CNT_OUT_W-1:0] pointer_slot;
        logic [CNT_OUT_W-1:0] words_used;
    } abp_out_t;

endpackage

[hdl/abp_ram.sv]
// generic single-port-write ram with registered read
module abp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/attribute_row_bit_packer.sv]
// attribute row bit packer top level: decode, first-fit scan and result register
// Each item is taken in the idle state and decoded in the next cycle. A clear, a
// rejected kind or a wide field that does not fit then goes straight to the emit
// state. A field of a word or more appends its words through the map ram's write
// port, one word a cycle. A narrower field scans the selected map first-fit, one
// entry a cycle through the ram's registered read port, reading at most the words
// in use in that map, and appends a new word if none fits. The output register lets
// a new item enter while the last result still waits. Map entries at or above the
// word count are never read, so the maps need no clearing after reset or after a
// clear item.
`include "attribute_row_bit_packer_macros.svh"

module attribute_row_bit_packer
    import abp_pkg::*;
#(
    parameter int WORD_BITS    = WORD_BITS_DEF,
    parameter int POINTER_BITS = POINTER_BITS_DEF,
    parameter int MAX_WORDS    = MAX_WORDS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  abp_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output abp_out_t out_data
);

    localparam int IDX_W     = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int UB_W      = $clog2(WORD_BITS + 1);
    localparam int OFF_W     = $clog2(MAX_WORDS * WORD_BITS + 1);
    localparam int SUM_W     = BITS_W + 1;
    localparam int MAX_ITEMS = (MAX_FIELD_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ITEM_W    = $clog2(MAX_ITEMS + 1);
    localparam int CHK_W     = CNT_W + ITEM_W + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WIDE   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    abp_in_t                item_reg, item_next;
    logic [CNT_W-1:0]       stat_cnt_reg, stat_cnt_next;
    logic [CNT_W-1:0]       dyn_cnt_reg, dyn_cnt_next;
    logic [PTR_CNT_W-1:0]   str_ptr_reg, str_ptr_next;
    logic [PTR_CNT_W-1:0]   fac_ptr_reg, fac_ptr_next;
    logic [BITS_W-1:0]      bits_reg, bits_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]       widx_reg, widx_next;
    logic [ITEM_W-1:0]      left_reg, left_next;
    abp_out_t               res_reg, res_next;
    logic                   out_valid_reg;
    abp_out_t               out_data_reg;

    logic [CNT_W-1:0]       cnt_sel;
    logic [CNT_W-1:0]       cnt_new;
    logic                   cnt_we;
    logic                   clear_all;
    logic                   ptr_inc;
    logic [BITS_W-1:0]      bits_dec;
    logic                   reject_dec;
    logic                   is_ptr;
    logic [ITEM_W-1:0]      items_dec;
    logic [UB_W-1:0]        rdata_sel;
    logic [UB_W-1:0]        stat_rdata, dyn_rdata;
    logic [SUM_W-1:0]       fit_sum;
    logic                   fit;
    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [UB_W-1:0]        ram_wdata;
    logic                   out_load;

    logic                   res_load;
    logic [STATUS_W-1:0]    res_status;
    logic [BITS_W-1:0]      res_bits;
    logic                   res_placed;
    logic [CNT_W-1:0]       off_idx;
    logic [UB_W-1:0]        off_used;
    logic [CNT_W-1:0]       words_src;
    logic [OFF_W-1:0]                 off_full;
    logic [OFF_W+OFF_OUT_W-1:0]       off_ext;
    logic [CNT_W+CNT_OUT_W-1:0]       words_ext;
    logic [CNT_W+CNT_OUT_W-1:0]       slot_ext;

    assign cnt_sel   = item_reg.map_select ? dyn_cnt_reg : stat_cnt_reg;
    assign rdata_sel = item_reg.map_select ? dyn_rdata : stat_rdata;
    assign is_ptr    = (item_reg.attr_kind == KIND_STR_PTR) ||
                       (item_reg.attr_kind == KIND_FAC_PTR);
    assign fit_sum   = SUM_W'(rdata_sel) + SUM_W'(bits_reg);
    assign fit       = chk_vld_reg && (fit_sum <= SUM_W'(WORD_BITS));
    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // field width from kind
    always_comb
    begin
        bits_dec   = '0;
        reject_dec = 1'b0;
        unique case (item_reg.attr_kind)
            KIND_PLAIN:
            begin
                if (item_reg.requested_bits == '0)
                begin
                    bits_dec = BITS_W'(WORD_BITS);
                end
                else if (item_reg.requested_bits > WIDE_BITS)
                begin
                    bits_dec = WIDE_BITS;
                end
                else
                begin
                    bits_dec = item_reg.requested_bits;
                end
            end
            KIND_BOOL:    bits_dec = BITS_W'(1);
            KIND_WIDE64:  bits_dec = WIDE_BITS;
            KIND_STR_PTR,
            KIND_FAC_PTR: bits_dec = BITS_W'(POINTER_BITS);
            default:      reject_dec = 1'b1;
        endcase
    end

    // whole words needed by a wide field
    always_comb
    begin
        items_dec = '0;
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            if (SUM_W'(k * WORD_BITS) < SUM_W'(bits_dec))
            begin
                items_dec = ITEM_W'(items_dec + ITEM_W'(1));
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        bits_next    = bits_reg;
        rd_idx_next  = rd_idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        widx_next    = widx_reg;
        left_next    = left_reg;
        cnt_we       = 1'b0;
        cnt_new      = cnt_sel;
        clear_all    = 1'b0;
        ptr_inc      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = widx_reg;
        ram_wdata    = UB_W'(WORD_BITS);
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg[IDX_W-1:0];
        res_load     = 1'b0;
        res_status   = ST_PLACED;
        res_bits     = bits_reg;
        res_placed   = 1'b0;
        off_idx      = cnt_sel;
        off_used     = '0;
        words_src    = cnt_sel;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                bits_next = bits_dec;
                if (item_reg.command == CMD_CLEAR)
                begin
                    clear_all  = 1'b1;
                    res_load   = 1'b1;
                    words_src  = '0;
                    state_next = S_EMIT;
                end
                else if (reject_dec)
                begin
                    res_load   = 1'b1;
                    res_status = ST_REJECT;
                    state_next = S_EMIT;
                end
                else if (bits_dec >= BITS_W'(WORD_BITS))
                begin
                    if (CHK_W'(cnt_sel) + CHK_W'(items_dec) > CHK_W'(MAX_WORDS))
                    begin
                        res_load   = 1'b1;
                        res_status = ST_FULL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cnt_we     = 1'b1;
                        cnt_new    = CNT_W'(cnt_sel + CNT_W'(items_dec));
                        ptr_inc    = is_ptr;
                        widx_next  = cnt_sel[IDX_W-1:0];
                        left_next  = items_dec;
                        res_load   = 1'b1;
                        res_placed = 1'b1;
                        res_bits   = bits_dec;
                        words_src  = cnt_new;
                        state_next = S_WIDE;
                    end
                end
                else
                begin
                    rd_idx_next = '0;
                    state_next  = S_SCAN;
                end
            end
            S_WIDE:
            begin
                ram_we    = 1'b1;
                widx_next = IDX_W'(widx_reg + IDX_W'(1));
                left_next = ITEM_W'(left_reg - ITEM_W'(1));
                if (left_reg == ITEM_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (fit)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = chk_idx_reg;
                    ram_wdata  = UB_W'(fit_sum);
                    ptr_inc    = is_ptr;
                    res_load   = 1'b1;
                    res_placed = 1'b1;
                    off_idx    = CNT_W'(chk_idx_reg);
                    off_used   = rdata_sel;
                    state_next = S_EMIT;
                end
                else if (rd_idx_reg == cnt_sel)
                begin
                    res_load   = 1'b1;
                    state_next = S_EMIT;
                    if (cnt_sel >= CNT_W'(MAX_WORDS))
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = cnt_sel[IDX_W-1:0];
                        ram_wdata  = UB_W'(bits_reg);
                        cnt_we     = 1'b1;
                        cnt_new    = CNT_W'(cnt_sel + CNT_W'(1));
                        ptr_inc    = is_ptr;
                        res_placed = 1'b1;
                        words_src  = cnt_new;
                    end
                end
                else
                begin
                    ram_re       = 1'b1;
                    rd_idx_next  = CNT_W'(rd_idx_reg + CNT_W'(1));
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // result assembly
    assign off_full  = OFF_W'(off_idx) * OFF_W'(WORD_BITS) + OFF_W'(off_used);
    assign off_ext   = (OFF_W + OFF_OUT_W)'(off_full);
    assign words_ext = (CNT_W + CNT_OUT_W)'(words_src);
    assign slot_ext  = (CNT_W + CNT_OUT_W)'(cnt_sel);

    always_comb
    begin
        res_next = res_reg;
        if (res_load)
        begin
            res_next.status       = res_status;
            res_next.bit_offset   = res_placed ? off_ext[OFF_OUT_W-1:0] : '0;
            res_next.bit_count    = res_placed ? res_bits : '0;
            res_next.pointer_slot = (res_placed && is_ptr) ? slot_ext[CNT_OUT_W-1:0] : '0;
            res_next.words_used   = words_ext[CNT_OUT_W-1:0];
        end
    end

    // counts and pointer counters
    always_comb
    begin
        stat_cnt_next = stat_cnt_reg;
        dyn_cnt_next  = dyn_cnt_reg;
        str_ptr_next  = str_ptr_reg;
        fac_ptr_next  = fac_ptr_reg;
        if (clear_all)
        begin
            stat_cnt_next = '0;
            dyn_cnt_next  = '0;
            str_ptr_next  = '0;
            fac_ptr_next  = '0;
        end
        else
        begin
            if (cnt_we && item_reg.map_select)
            begin
                dyn_cnt_next = cnt_new;
            end
            if (cnt_we && !item_reg.map_select)
            begin
                stat_cnt_next = cnt_new;
            end
            if (ptr_inc && item_reg.attr_kind == KIND_STR_PTR && str_ptr_reg < PTR_CNT_MAX)
            begin
                str_ptr_next = PTR_CNT_W'(str_ptr_reg + PTR_CNT_W'(1));
            end
            if (ptr_inc && item_reg.attr_kind == KIND_FAC_PTR && fac_ptr_reg < PTR_CNT_MAX)
            begin
                fac_ptr_next = PTR_CNT_W'(fac_ptr_reg + PTR_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stat_cnt_reg  <= '0;
            dyn_cnt_reg   <= '0;
            str_ptr_reg   <= '0;
            fac_ptr_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            stat_cnt_reg <= stat_cnt_next;
            dyn_cnt_reg  <= dyn_cnt_next;
            str_ptr_reg  <= str_ptr_next;
            fac_ptr_reg  <= fac_ptr_next;
            chk_vld_reg  <= chk_vld_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        bits_reg    <= bits_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        widx_reg    <= widx_next;
        left_reg    <= left_next;
        res_reg     <= res_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // used-bits maps
    abp_ram #(
        .WIDTH (UB_W),
        .DEPTH (MAX_WORDS)
    ) u_stat_map (
        .clk   (clk),
        .we    (ram_we && !item_reg.map_select),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re && !item_reg.map_select),
        .raddr (ram_raddr),
        .rdata (stat_rdata)
    );

    abp_ram #(
        .WIDTH (UB_W),
        .DEPTH (MAX_WORDS)
    ) u_dyn_map (
        .clk   (clk),
        .we    (ram_we && item_reg.map_select),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re && item_reg.map_select),
        .raddr (ram_raddr),
        .rdata (dyn_rdata)
    );

    `ABP_NEVER(a_stat_cnt_range, stat_cnt_reg > CNT_W'(MAX_WORDS), "static count beyond depth")
    `ABP_NEVER(a_dyn_cnt_range, dyn_cnt_reg > CNT_W'(MAX_WORDS), "dynamic count beyond depth")
    `ABP_ASSERT(a_read_below_cnt, ram_re |-> (rd_idx_reg < cnt_sel), "map read past count")
    `ABP_ASSERT(a_accept_decode, in_valid && in_ready |=> state_reg == S_DECODE, "not decoded")
    `ABP_ASSERT(a_emit_loads, state_reg == S_EMIT && !out_valid_reg |=> out_valid_reg, "no result")

endmodule

[verif/abp_placement_checker.sv]
// placement predictor and result comparator for the attribute row bit packer
`timescale 1ns / 100ps

module abp_placement_checker
    import abp_pkg::*;
#(
    parameter int WORD_BITS    = WORD_BITS_DEF,
    parameter int POINTER_BITS = POINTER_BITS_DEF,
    parameter int MAX_WORDS    = MAX_WORDS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  abp_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  abp_out_t out_data,
    output int       error_count,
    output int       pending_count
);

    localparam int REPORT_LIMIT = 10;

    int unsigned used_bits [2][MAX_WORDS];
    int unsigned word_count [2];
    int unsigned str_ptr_count;
    int unsigned fac_ptr_count;

    abp_out_t placement_fifo [$];

    function automatic abp_out_t predict_placement(abp_in_t item);
        abp_out_t               res;
        int unsigned            sel;
        int unsigned            n;
        int unsigned            bits;
        int unsigned            offset;
        int unsigned            slot;
        int unsigned            words;
        int unsigned            idx;
        logic [STATUS_W-1:0]    st;
        bit                     is_ptr;
        res    = '0;
        offset = 0;
        slot   = 0;
        bits   = 0;
        is_ptr = 1'b0;
        st     = ST_PLACED;
        if (item.command == CMD_CLEAR)
        begin
            word_count[0] = 0;
            word_count[1] = 0;
            str_ptr_count = 0;
            fac_ptr_count = 0;
            return res;
        end
        sel = item.map_select;
        n   = word_count[sel];
        case (item.attr_kind)
            KIND_PLAIN:
            begin
                if (item.requested_bits == 0)
                    bits = WORD_BITS;
                else if (item.requested_bits > MAX_FIELD_BITS)
                    bits = MAX_FIELD_BITS;
                else
                    bits = item.requested_bits;
            end
            KIND_BOOL:    bits = 1;
            KIND_WIDE64:  bits = MAX_FIELD_BITS;
            KIND_STR_PTR, KIND_FAC_PTR:
            begin
                bits   = POINTER_BITS;
                is_ptr = 1'b1;
            end
            default:      st = ST_REJECT;
        endcase
        if (st == ST_PLACED)
        begin
            if (bits >= WORD_BITS)
            begin
                words = (bits + WORD_BITS - 1) / WORD_BITS;
                if (n + words > MAX_WORDS)
                    st = ST_FULL;
                else
                begin
                    offset = n * WORD_BITS;
                    for (int i = 0; i < words; i++)
                        used_bits[sel][n + i] = WORD_BITS;
                    slot = n;
                    word_count[sel] = n + words;
                end
            end
            else
            begin
                // first fit over the words in use
                idx = 0;
                while (idx < n && used_bits[sel][idx] + bits > WORD_BITS)
                    idx++;
                if (idx == n && n >= MAX_WORDS)
                    st = ST_FULL;
                else
                begin
                    if (idx == n)
                    begin
                        used_bits[sel][idx] = 0;
                        word_count[sel] = n + 1;
                    end
                    offset = idx * WORD_BITS + used_bits[sel][idx];
                    used_bits[sel][idx] = used_bits[sel][idx] + bits;
                    slot = n;
                end
            end
            if (st == ST_PLACED && is_ptr)
            begin
                if (item.attr_kind == KIND_STR_PTR)
                begin
                    if (str_ptr_count < PTR_CNT_MAX)
                        str_ptr_count++;
                end
                else if (fac_ptr_count < PTR_CNT_MAX)
                    fac_ptr_count++;
            end
        end
        if (st != ST_PLACED)
        begin
            offset = 0;
            bits   = 0;
            slot   = 0;
        end
        if (!is_ptr)
            slot = 0;
        res.status       = st;
        res.bit_offset   = OFF_OUT_W'(offset);
        res.bit_count    = BITS_W'(bits);
        res.pointer_slot = CNT_OUT_W'(slot);
        res.words_used   = CNT_OUT_W'(word_count[sel]);
        return res;
    endfunction

    always @(posedge clk)
    begin
        abp_out_t want;
        if (!rst_n)
        begin
            word_count[0] = 0;
            word_count[1] = 0;
            str_ptr_count = 0;
            fac_ptr_count = 0;
            placement_fifo.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                placement_fifo.push_back(predict_placement(in_data));
            if (out_valid && out_ready)
            begin
                if (placement_fifo.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result st=%0d off=%0d cnt=%0d slot=%0d words=%0d",
                                 $realtime, out_data.status, out_data.bit_offset,
                                 out_data.bit_count, out_data.pointer_slot,
                                 out_data.words_used);
                end
                else
                begin
                    want = placement_fifo.pop_front();
                    if (out_data.status !== want.status
                        || out_data.bit_offset !== want.bit_offset
                        || out_data.bit_count !== want.bit_count
                        || out_data.pointer_slot !== want.pointer_slot
                        || out_data.words_used !== want.words_used)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: mismatch exp st=%0d off=%0d cnt=%0d slot=%0d words=%0d got st=%0d off=%0d cnt=%0d slot=%0d words=%0d",
                                     $realtime, want.status, want.bit_offset,
                                     want.bit_count, want.pointer_slot, want.words_used,
                                     out_data.status, out_data.bit_offset,
                                     out_data.bit_count, out_data.pointer_slot,
                                     out_data.words_used);
                    end
                end
            end
            pending_count = placement_fifo.size();
        end
    end

endmodule

[verif/testbench.sv]
// stimulus, flow control and verdict for the attribute row bit packer
`timescale 1ns / 100ps

module testbench;
    import abp_pkg::*;

    localparam int RANDOM_ITEMS  = 1150;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 80;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PERIOD  = 2;
    localparam int RX_SPARSE  = 3;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    abp_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    abp_out_t out_data;

    int       error_count;
    int       pending_count;
    int       stall_cycles;
    int       burst_left;

    attribute_row_bit_packer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    abp_placement_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic abp_in_t make_item(logic cmd, logic [KIND_W-1:0] kind,
                                          logic [BITS_W-1:0] req, logic sel);
        abp_in_t item;
        item.command        = cmd;
        item.attr_kind      = kind;
        item.requested_bits = req;
        item.map_select     = sel;
        return item;
    endfunction

    task automatic send_item(abp_in_t item);
        int gap;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // receiver flow control
    initial
    begin
        int mode;
        int span;
        int period;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode   = $urandom_range(RX_ALWAYS, RX_SPARSE);
            span   = $urandom_range(10, 300);
            period = $urandom_range(2, 16);
            for (int c = 0; c < span; c++)
            begin
                @(posedge clk);
                case (mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIOD: out_ready <= ((c % period) == 0);
                    default:   out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no accepted item or result
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        abp_in_t            item;
        abp_in_t            directed [$];
        int                 pick;
        logic [KIND_W-1:0]  kind;
        logic [BITS_W-1:0]  req;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_item(CMD_CLEAR, KIND_NONE, 7'd0, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd0, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd1, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd31, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_BOOL, 7'd0, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd33, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd64, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd65, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd127, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_WIDE64, 7'd5, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_STR_PTR, 7'd0, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_FAC_PTR, 7'd127, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_NONE, 7'd12, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_FAC_PTR + 3'd1, 7'd12, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_FAC_PTR + 3'd2, 7'd127, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_BOOL, 7'd0, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd16, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd16, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_PLAIN, 7'd17, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_BOOL, 7'd127, 1'b0));
        directed.push_back(make_item(CMD_CLEAR, KIND_FAC_PTR + 3'd2, 7'd127, 1'b1));
        directed.push_back(make_item(CMD_PLACE, KIND_BOOL, 7'd0, 1'b0));
        directed.push_back(make_item(CMD_PLACE, KIND_STR_PTR, 7'd64, 1'b1));
        foreach (directed[i])
            send_item(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                kind = KIND_PLAIN;
            else if (pick < 55)
                kind = KIND_BOOL;
            else if (pick < 65)
                kind = KIND_WIDE64;
            else if (pick < 75)
                kind = KIND_STR_PTR;
            else if (pick < 85)
                kind = KIND_FAC_PTR;
            else if (pick < 90)
                kind = KIND_NONE;
            else
                kind = KIND_FAC_PTR + 3'($urandom_range(1, 2));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                req = BITS_W'($urandom_range(1, 31));
            else if (pick < 55)
                req = '0;
            else if (pick < 70)
                req = BITS_W'($urandom_range(32, 64));
            else if (pick < 80)
                req = BITS_W'($urandom_range(65, 127));
            else
                req = BITS_W'($urandom_range(0, 127));
            // clears are rare so the maps run full
            item = make_item(($urandom_range(0, 179) == 0) ? CMD_CLEAR : CMD_PLACE,
                             kind, req, 1'($urandom_range(0, 1)));
            send_item(item);
        end
        if (in_valid)
            in_valid <= 1'b0;

        // let the checker take in the last item before draining
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[attribute_row_bit_packer.f]
+incdir+hdl
hdl/abp_pkg.sv
hdl/abp_ram.sv
hdl/attribute_row_bit_packer.sv
verif/abp_placement_checker.sv
verif/testbench.sv
